// File: hw/rtl/dfl_pkg.sv
`default_nettype none

package dfl_pkg;

    // Fraction bits of log2, one per squaring stage
    localparam int FRAC_BITS = 28;
    localparam int EXP_W     = 5;
    localparam int MANT_W    = 32;

    // log10(2) in Q0.32, truncated
    localparam logic [31:0] LOG10_2_Q32 = 32'd1292913986;
    localparam logic [31:0] Q16_MAX     = 32'h7FFF_FFFF;

    // Stage counts of each section and of the whole pipeline
    localparam int FRONT_LAT = 5;
    localparam int SCALE_LAT = 3;
    localparam int PIPE_LAT  = FRONT_LAT + FRAC_BITS + SCALE_LAT;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic        fold_mode;
        logic [30:0] floor_value;
        logic [30:0] offset_value;
    } t_cfg;

    // One item in flight through the log2 section
    typedef struct packed {
        logic                 valid;
        logic [EXP_W-1:0]     expo;
        logic [MANT_W-1:0]    mant;
        logic [FRAC_BITS-1:0] frac;
    } t_log_stage;

endpackage

`default_nettype wire

// File: hw/rtl/divergence_fold_log10_unit.sv
`default_nettype none

// Base-10 logarithm of a folded Q16.16 field sample, returned in Q4.16.
// One sample is taken in every cycle (start while busy is low; busy never
// rises) and its result appears on o_log_value with o_log_valid after
// five front stages (magnitude, fold, floor, leading one, normalize), one
// squaring multiplier stage per log2 fraction bit (28), and three scale
// stages for the log10(2) product and rounding. Results are
// strobed for one cycle and must be taken then. Registers sit at byte
// addresses 0 (fold_mode), 4 (floor_value) and 8 (offset_value) and are
// to be written only while no item is in flight.
module divergence_fold_log10_unit (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire logic [31:0]  i_sample,
    output logic              o_log_valid,
    output logic signed [19:0] o_log_value,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import dfl_pkg::*;

    localparam logic [1:0] REG_FOLD_MODE = 2'd0;
    localparam logic [1:0] REG_FLOOR     = 2'd1;
    localparam logic [1:0] REG_OFFSET    = 2'd2;

    logic        r_fold_mode;
    logic [30:0] r_floor_value;
    logic [30:0] r_offset_value;
    logic        w_wr;
    t_cfg        w_cfg;
    t_log_stage  w_chain [0:FRAC_BITS];

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign w_wr   = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fold_mode    <= 1'b0;
            r_floor_value  <= 31'd65536;
            r_offset_value <= 31'd6553600;
        end else if (w_wr) begin
            unique case (paddr[3:2])
                REG_FOLD_MODE: r_fold_mode    <= pwdata[0];
                REG_FLOOR:     r_floor_value  <= pwdata[30:0];
                REG_OFFSET:    r_offset_value <= pwdata[30:0];
                default:       ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (paddr[3:2])
            REG_FOLD_MODE: prdata = {31'd0, r_fold_mode};
            REG_FLOOR:     prdata = {1'b0, r_floor_value};
            REG_OFFSET:    prdata = {1'b0, r_offset_value};
            default:       prdata = '0;
        endcase
    end

    assign w_cfg.fold_mode    = r_fold_mode;
    assign w_cfg.floor_value  = r_floor_value;
    assign w_cfg.offset_value = r_offset_value;

    dfl_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (start && !busy),
        .i_sample (i_sample),
        .i_cfg    (w_cfg),
        .o_stage  (w_chain[0])
    );

    // One squaring stage per fraction bit
    for (genvar g = 0; g < FRAC_BITS; g++) begin : g_sqr
        dfl_sqr_stage u_sqr (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (w_chain[g]),
            .o_stage (w_chain[g+1])
        );
    end

    dfl_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_stage     (w_chain[FRAC_BITS]),
        .o_valid     (o_log_valid),
        .o_log_value (o_log_value)
    );

    // Every result traces back to a start a fixed latency earlier
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_log_valid |-> $past(start, PIPE_LAT))
        else $error("result without matching start");

    // Results stay inside the log10 range of Q16.16 magnitudes
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_log_valid |-> ((o_log_value >= -20'sd327680) && (o_log_value <= 20'sd327680)))
        else $error("log result out of range");

    // The mantissa stays normalized after all squaring stages
    a_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chain[FRAC_BITS].valid |-> w_chain[FRAC_BITS].mant[MANT_W-1])
        else $error("mantissa lost normalization");

    // A mode write lands in the register
    a_mode_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr && (paddr[3:2] == REG_FOLD_MODE)) |=> (r_fold_mode == $past(pwdata[0])))
        else $error("fold mode write lost");

endmodule

`default_nettype wire

// File: hw/rtl/dfl_front.sv
`default_nettype none

module dfl_front (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    input  wire logic [31:0]         i_sample,
    input  wire dfl_pkg::t_cfg       i_cfg,
    output dfl_pkg::t_log_stage      o_stage
);
    import dfl_pkg::*;

    logic        r_s1_valid, r_s2_valid, r_s3_valid, r_s4_valid;
    logic        r_s1_neg;
    logic [31:0] r_s1_abs;
    logic [31:0] r_s2_mag;
    logic [31:0] r_s3_x;
    logic [31:0] r_s4_x;
    logic [4:0]  r_s4_e;
    t_log_stage  r_out;

    logic [31:0] n_s1_abs;
    logic [32:0] w_sum, w_diff, w_pick;
    logic [31:0] n_s2_mag;
    logic [31:0] w_floor;
    logic [31:0] n_s3_x;
    logic [4:0]  n_s4_e;
    logic [31:0] n_mant;

    // Magnitude of the sample; the most negative code gives 2^31
    assign n_s1_abs = i_sample[31] ? (~i_sample + 32'd1) : i_sample;

    // In fold mode fold around offset, saturate at Q16.16 max
    always_comb begin
        w_sum  = 33'(r_s1_abs) + 33'(i_cfg.offset_value);
        w_diff = 33'(i_cfg.offset_value) - 33'(r_s1_abs);
        if (r_s1_neg || (r_s1_abs >= 32'(i_cfg.offset_value))) begin
            w_pick = w_sum;
        end else begin
            w_pick = w_diff;
        end
        if (!i_cfg.fold_mode) begin
            n_s2_mag = r_s1_abs;
        end else if (w_pick > 33'(Q16_MAX)) begin
            n_s2_mag = Q16_MAX;
        end else begin
            n_s2_mag = w_pick[31:0];
        end
    end

    // Clamp to the floor; a zero floor counts as one LSB
    assign w_floor = (i_cfg.floor_value == 31'd0) ? 32'd1 : 32'(i_cfg.floor_value);
    assign n_s3_x  = (r_s2_mag > w_floor) ? r_s2_mag : w_floor;

    // Find the leading one
    always_comb begin
        n_s4_e = '0;
        for (int i = 0; i < 32; i++) begin
            if (r_s3_x[i]) begin
                n_s4_e = 5'(i);
            end
        end
    end

    // Normalize to Q1.31
    assign n_mant = r_s4_x << (5'd31 - r_s4_e);

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out.valid <= 1'b0;
        end else begin
            r_s1_valid  <= i_valid;
            r_s2_valid  <= r_s1_valid;
            r_s3_valid  <= r_s2_valid;
            r_s4_valid  <= r_s3_valid;
            r_out.valid <= r_s4_valid;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r_s1_neg   <= i_sample[31];
        r_s1_abs   <= n_s1_abs;
        r_s2_mag   <= n_s2_mag;
        r_s3_x     <= n_s3_x;
        r_s4_x     <= r_s3_x;
        r_s4_e     <= n_s4_e;
        r_out.expo <= r_s4_e;
        r_out.mant <= n_mant;
        r_out.frac <= '0;
    end

    assign o_stage = r_out;

endmodule

`default_nettype wire

// File: hw/rtl/dfl_sqr_stage.sv
`default_nettype none

module dfl_sqr_stage (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire dfl_pkg::t_log_stage i_stage,
    output dfl_pkg::t_log_stage      o_stage
);
    import dfl_pkg::*;

    t_log_stage  r_out;
    logic [63:0] w_sq;
    logic [32:0] w_top;
    logic        w_bit;
    logic [31:0] n_mant;

    // Square the mantissa; an overflow past 2.0 yields a one bit
    assign w_sq   = 64'(i_stage.mant) * 64'(i_stage.mant);
    assign w_top  = w_sq[63:31];
    assign w_bit  = w_top[32];
    assign n_mant = w_bit ? w_top[32:1] : w_top[31:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else begin
            r_out.valid <= i_stage.valid;
        end
    end

    // Shift the new bit into the fraction
    always_ff @(posedge i_clk) begin
        r_out.expo <= i_stage.expo;
        r_out.mant <= n_mant;
        r_out.frac <= {i_stage.frac[FRAC_BITS-2:0], w_bit};
    end

    assign o_stage = r_out;

endmodule

`default_nettype wire

// File: hw/rtl/dfl_scale.sv
`default_nettype none

module dfl_scale (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire dfl_pkg::t_log_stage i_stage,
    output logic                     o_valid,
    output logic signed [19:0]       o_log_value
);
    import dfl_pkg::*;

    localparam logic [64:0] ROUND_BIAS = 65'd1 << 43;

    logic               r_a_valid, r_b_valid, r_c_valid;
    logic               r_a_neg, r_b_neg;
    logic [32:0]        r_a_mag;
    logic [48:0]        r_b_lo;
    logic [47:0]        r_b_hi;
    logic signed [19:0] r_c_log;

    logic        n_a_neg;
    logic [32:0] n_a_mag;
    logic [48:0] n_b_lo;
    logic [47:0] n_b_hi;
    logic [64:0] w_sum;
    logic [19:0] w_round;

    // Magnitude of log2 in Q.28 and its sign
    always_comb begin
        n_a_neg = (i_stage.expo < 5'd16);
        if (n_a_neg) begin
            n_a_mag = (33'(5'd16 - i_stage.expo) << FRAC_BITS) - 33'(i_stage.frac);
        end else begin
            n_a_mag = (33'(i_stage.expo - 5'd16) << FRAC_BITS) + 33'(i_stage.frac);
        end
    end

    // Split the scale product into two partial products
    assign n_b_lo = 49'(r_a_mag[16:0]) * 49'(LOG10_2_Q32);
    assign n_b_hi = 48'(r_a_mag[32:17]) * 48'(LOG10_2_Q32);

    // Combine, round half away from zero, restore the sign
    assign w_sum   = {r_b_hi, 17'b0} + 65'(r_b_lo) + ROUND_BIAS;
    assign w_round = w_sum[63:44];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= i_stage.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_neg <= n_a_neg;
        r_a_mag <= n_a_mag;
        r_b_neg <= r_a_neg;
        r_b_lo  <= n_b_lo;
        r_b_hi  <= n_b_hi;
        r_c_log <= r_b_neg ? signed'(20'd0 - w_round) : signed'(w_round);
    end

    assign o_valid     = r_c_valid;
    assign o_log_value = r_c_log;

endmodule

`default_nettype wire
